// File: sv/slot_allocator_with_hole_stack_defines.svh
// Assertion macros shared by the slot allocator RTL.
`ifndef SLOT_ALLOCATOR_WITH_HOLE_STACK_DEFINES_SVH
`define SLOT_ALLOCATOR_WITH_HOLE_STACK_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SAHS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define SAHS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/sahs_pkg.sv
// Types and constants for the slot allocator with hole stack.
`timescale 1ns / 1ps

package sahs_pkg;

    localparam int REQ_W    = 3;
    localparam int POS_W    = 8;
    localparam int WDATA_W  = 32;
    localparam int STATUS_W = 2;
    localparam int SLOT_W   = 8;
    localparam int RDATA_W  = 32;
    localparam int FILL_W   = 9;

    typedef enum logic [REQ_W-1:0] {
        REQ_INSERT  = 3'd0,
        REQ_REPLACE = 3'd1,
        REQ_DELETE  = 3'd2,
        REQ_READ    = 3'd3,
        REQ_POP     = 3'd4
    } req_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_HOLE  = 2'd1,
        STAT_RANGE = 2'd2,
        STAT_FULL  = 2'd3
    } status_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } state_t;

endpackage

// File: sv/sahs_ram.sv
// Single-port-write, single-port-read synchronous RAM with registered read data.
`timescale 1ns / 1ps

module sahs_ram #(
    parameter int WIDTH = 33,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: sv/slot_allocator_with_hole_stack.sv
// Top level: slot store with fill length and a LIFO stack of freed holes.
//
//  channel | valid     | stall     | payload
//  --------+-----------+-----------+-----------------------------------------------
//  request | req_valid | req_stall | req_type, position, write_data
//  result  | rsp_valid | rsp_stall | status, slot_index, read_data, fill_length
//
// The accept cycle issues the reads of the element RAM and the hole stack RAM;
// S_EXEC then resolves the request and writes back; no new request is taken before
// it resolves. S_EXEC waits while a prior result is held under rsp_stall.
// Each element word carries a hole flag; it is written on every append, so no
// clearing pass is needed after reset. Reset clears the counts and control only.
`timescale 1ns / 1ps

module slot_allocator_with_hole_stack #(
    parameter int CAPACITY = 256,
    parameter int DATA_W   = 32
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             req_valid,
    output logic                             req_stall,
    input  logic [sahs_pkg::REQ_W-1:0]       req_type,
    input  logic [sahs_pkg::POS_W-1:0]       position,
    input  logic [sahs_pkg::WDATA_W-1:0]     write_data,
    output logic                             rsp_valid,
    input  logic                             rsp_stall,
    output logic [sahs_pkg::STATUS_W-1:0]    status,
    output logic [sahs_pkg::SLOT_W-1:0]      slot_index,
    output logic [sahs_pkg::RDATA_W-1:0]     read_data,
    output logic [sahs_pkg::FILL_W-1:0]      fill_length
);

    import sahs_pkg::*;

    `include "slot_allocator_with_hole_stack_defines.svh"

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int LEN_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (LEN_W > POS_W) ? LEN_W : POS_W;

    // FSM and request capture
    state_t                  state_reg, state_next;
    logic [REQ_W-1:0]        req_type_reg;
    logic [POS_W-1:0]        position_reg;
    logic [DATA_W-1:0]       write_data_reg;
    logic                    req_fire;
    logic                    ex_fire;
    logic                    out_free;

    // counts
    logic [LEN_W-1:0]        length_reg, length_next;
    logic [LEN_W-1:0]        hole_reg, hole_next;

    // result register
    logic                    out_valid_reg;
    logic [STATUS_W-1:0]     status_reg, status_next;
    logic [SLOT_W-1:0]       slot_reg, slot_next;
    logic [RDATA_W-1:0]      rdata_reg, rdata_next;
    logic [FILL_W-1:0]       fill_reg;

    // memory ports
    logic                    elem_we;
    logic [IDX_W-1:0]        elem_waddr;
    logic [DATA_W:0]         elem_wdata;
    logic [IDX_W-1:0]        elem_raddr;
    logic [DATA_W:0]         elem_rdata;
    logic                    hole_we;
    logic [IDX_W-1:0]        hole_waddr;
    logic [IDX_W-1:0]        hole_raddr;
    logic [IDX_W-1:0]        hole_rdata;

    // resolve helpers
    logic                    in_range;
    logic                    is_tail;
    logic                    elem_hole;
    logic [DATA_W-1:0]       elem_data;
    logic [IDX_W-1:0]        pos_idx;
    logic [LEN_W-1:0]        len_tail;

    assign out_free = !out_valid_reg || !rsp_stall;

    // ---------------- FSM ----------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req_stall = 1'b1;
        ex_fire   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                req_stall = 1'b0;
            end
            S_EXEC:
            begin
                ex_fire = out_free;
            end
            default:
            begin
                req_stall = 1'b1;
            end
        endcase
    end

    assign req_fire = req_valid && !req_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            req_type_reg   <= req_type;
            position_reg   <= position;
            write_data_reg <= DATA_W'(write_data);
        end
    end

    // ---------------- memory reads at accept ----------------
    assign elem_raddr = (req_type == REQ_POP) ? IDX_W'(length_reg - 1'b1) : IDX_W'(position);
    assign hole_raddr = IDX_W'(hole_reg - 1'b1);

    sahs_ram #(
        .WIDTH (DATA_W + 1),
        .DEPTH (CAPACITY)
    ) u_elem_ram (
        .clk   (clk),
        .we    (elem_we),
        .waddr (elem_waddr),
        .wdata (elem_wdata),
        .re    (req_fire),
        .raddr (elem_raddr),
        .rdata (elem_rdata)
    );

    sahs_ram #(
        .WIDTH (IDX_W),
        .DEPTH (CAPACITY)
    ) u_hole_ram (
        .clk   (clk),
        .we    (hole_we),
        .waddr (hole_waddr),
        .wdata (pos_idx),
        .re    (req_fire),
        .raddr (hole_raddr),
        .rdata (hole_rdata)
    );

    // ---------------- resolve and write back ----------------
    assign pos_idx   = IDX_W'(position_reg);
    assign len_tail  = length_reg - 1'b1;
    assign elem_hole = elem_rdata[DATA_W];
    assign elem_data = elem_rdata[DATA_W-1:0];
    assign in_range  = (CMP_W'(position_reg) < CMP_W'(length_reg))
                    && (CMP_W'(position_reg) < CMP_W'(CAPACITY));
    assign is_tail   = (CMP_W'(position_reg) == CMP_W'(len_tail));

    always_comb
    begin
        length_next = length_reg;
        hole_next   = hole_reg;
        status_next = STAT_OK;
        slot_next   = '0;
        rdata_next  = '0;
        elem_we     = 1'b0;
        elem_waddr  = pos_idx;
        elem_wdata  = {1'b0, write_data_reg};
        hole_we     = 1'b0;
        hole_waddr  = IDX_W'(hole_reg);
        case (req_type_reg)
            REQ_INSERT:
            begin
                if (hole_reg != '0)
                begin
                    // reuse the most recently freed hole
                    hole_next  = hole_reg - 1'b1;
                    slot_next  = SLOT_W'(hole_rdata);
                    elem_we    = 1'b1;
                    elem_waddr = hole_rdata;
                end
                else if (length_reg == LEN_W'(CAPACITY))
                begin
                    status_next = STAT_FULL;
                end
                else
                begin
                    slot_next   = SLOT_W'(length_reg);
                    elem_we     = 1'b1;
                    elem_waddr  = IDX_W'(length_reg);
                    length_next = length_reg + 1'b1;
                end
            end
            REQ_REPLACE:
            begin
                if (!in_range)
                begin
                    status_next = STAT_RANGE;
                end
                else if (elem_hole)
                begin
                    status_next = STAT_HOLE;
                end
                else
                begin
                    elem_we = 1'b1;
                end
            end
            REQ_DELETE:
            begin
                if (!in_range)
                begin
                    status_next = STAT_RANGE;
                end
                else if (elem_hole)
                begin
                    status_next = STAT_HOLE;
                end
                else if (is_tail)
                begin
                    length_next = len_tail;
                    rdata_next  = RDATA_W'(elem_data);
                end
                else if (hole_reg != LEN_W'(CAPACITY))
                begin
                    // push a hole: flag the slot, keep its data
                    hole_we    = 1'b1;
                    hole_next  = hole_reg + 1'b1;
                    elem_we    = 1'b1;
                    elem_wdata = {1'b1, elem_data};
                end
            end
            REQ_READ:
            begin
                if (!in_range)
                begin
                    status_next = STAT_RANGE;
                end
                else if (elem_hole)
                begin
                    status_next = STAT_HOLE;
                end
                else
                begin
                    rdata_next = RDATA_W'(elem_data);
                end
            end
            REQ_POP:
            begin
                if (length_reg == '0)
                begin
                    status_next = STAT_RANGE;
                end
                else
                begin
                    length_next = len_tail;
                    rdata_next  = RDATA_W'(elem_data);
                end
            end
            default:
            begin
                status_next = STAT_RANGE;
            end
        endcase
        if (!ex_fire)
        begin
            elem_we = 1'b0;
            hole_we = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            length_reg    <= '0;
            hole_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ex_fire)
            begin
                length_reg    <= length_next;
                hole_reg      <= hole_next;
                out_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ex_fire)
        begin
            status_reg <= status_next;
            slot_reg   <= slot_next;
            rdata_reg  <= rdata_next;
            fill_reg   <= FILL_W'(length_next);
        end
    end

    assign rsp_valid   = out_valid_reg;
    assign status      = status_reg;
    assign slot_index  = slot_reg;
    assign read_data   = rdata_reg;
    assign fill_length = fill_reg;

    // ---------------- assertions ----------------
    `SAHS_ASSERT_NEXT(a_accept_to_exec, req_fire, state_reg == S_EXEC,
        "accepted request did not move to resolve")
    `SAHS_ASSERT_NOW(a_counts_only_on_resolve,
        (length_reg != $past(length_reg)) || (hole_reg != $past(hole_reg)),
        $past(ex_fire), "counts changed outside a resolve cycle")
    `SAHS_ASSERT_NOW(a_full_means_no_room,
        out_valid_reg && (status_reg == STAT_FULL),
        (length_reg == LEN_W'(CAPACITY)) && (hole_reg == '0),
        "full reported while room is left")

endmodule
